@@ src/skhst_pkg.sv @@
// shared types and constants for the string keyed hash slot table
`timescale 1ns / 1ps

package skhst_pkg;

  // djb2 starting value
  localparam logic [63:0] HASH_INIT = 64'd5381;

  // divider: remainder bits resolved per cycle and cycles per hash
  localparam int DIV_BITS = 4;
  localparam int DIV_CYCLES = 64 / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_CYCLES);

  // modulus and remainder width (slot count register width)
  localparam int MOD_W = 11;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_FINISH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic hash;
    logic start;
    logic div_step;
    logic clr_en;
    logic rd;
    logic commit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic out_busy;
  } sts_t;

endpackage

@@ src/skhst_ctrl.sv @@
// controller state machine for the hash slot table
`timescale 1ns / 1ps

module skhst_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                name_last,
  input  skhst_pkg::sts_t     sts,
  output logic                in_stall,
  output skhst_pkg::cmd_t     cmd
);

  skhst_pkg::state_t state;
  skhst_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skhst_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      skhst_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_next = skhst_pkg::ST_IDLE;
      end
      skhst_pkg::ST_IDLE: begin
        if (in_valid && name_last) state_next = skhst_pkg::ST_DIV;
      end
      skhst_pkg::ST_DIV: begin
        if (sts.div_last) state_next = skhst_pkg::ST_READ;
      end
      skhst_pkg::ST_READ: begin
        state_next = skhst_pkg::ST_FINISH;
      end
      skhst_pkg::ST_FINISH: begin
        if (!sts.out_busy) state_next = skhst_pkg::ST_IDLE;
      end
      default: begin
        state_next = skhst_pkg::ST_CLEAR;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      skhst_pkg::ST_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      skhst_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.hash = in_valid && !name_last;
        cmd.start = in_valid && name_last;
      end
      skhst_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      skhst_pkg::ST_READ: begin
        cmd.rd = 1'b1;
      end
      skhst_pkg::ST_FINISH: begin
        cmd.commit = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ src/skhst_dpath.sv @@
// datapath: djb2 accumulator, slot modulo divider, slot memory, result register
`timescale 1ns / 1ps

module skhst_dpath #(
  parameter int SLOTS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  skhst_pkg::cmd_t               cmd,
  output skhst_pkg::sts_t               sts,
  input  logic [skhst_pkg::MOD_W-1:0]   divisor,
  input  logic                          req_type,
  input  logic [7:0]                    name_byte,
  input  logic [15:0]                   rect_x,
  input  logic [15:0]                   rect_y,
  input  logic [15:0]                   rect_w,
  input  logic [15:0]                   rect_h,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          ok,
  output logic [15:0]                   out_x,
  output logic [15:0]                   out_y,
  output logic [15:0]                   out_w,
  output logic [15:0]                   out_h,
  output logic [9:0]                    slot_index
);

  localparam int AW = $clog2(SLOTS);
  localparam int MW = skhst_pkg::MOD_W;

  logic [63:0]                      acc;
  logic [63:0]                      hash_next;
  logic [63:0]                      dividend;
  logic [63:0]                      dividend_next;
  logic [MW-1:0]                    rem;
  logic [MW-1:0]                    rem_next;
  logic [MW-1:0]                    div_d;
  logic [skhst_pkg::DIV_CNT_W-1:0]  div_cnt;
  logic [AW-1:0]                    clr_cnt;
  logic                             req;
  logic [63:0]                      rect;
  logic [AW-1:0]                    addr;
  logic [AW-1:0]                    wr_addr;
  logic [63:0]                      rect_mem [SLOTS];
  logic                             valid_mem [SLOTS];
  logic [63:0]                      rd_rect;
  logic                             rd_valid;
  logic                             do_store;
  logic [63:0]                      res_rect;

  // djb2 step: acc * 33 + sign-extended byte
  assign hash_next = (acc << 5) + acc + {{56{name_byte[7]}}, name_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= skhst_pkg::HASH_INIT;
    end else if (cmd.hash) begin
      acc <= hash_next;
    end else if (cmd.start) begin
      acc <= skhst_pkg::HASH_INIT;
    end
  end

  // restoring remainder, a few bits per cycle
  always_comb begin
    logic [MW:0] trial;
    rem_next = rem;
    dividend_next = dividend;
    for (int i = 0; i < skhst_pkg::DIV_BITS; i++) begin
      trial = {rem_next, dividend_next[63]};
      dividend_next = {dividend_next[62:0], 1'b0};
      if (trial >= {1'b0, div_d}) begin
        trial = trial - {1'b0, div_d};
      end
      rem_next = trial[MW-1:0];
    end
  end

  // divider registers and latched request
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dividend <= hash_next;
      rem <= '0;
      div_d <= divisor;
      req <= req_type;
      rect <= {rect_h, rect_w, rect_y, rect_x};
    end else if (cmd.div_step) begin
      dividend <= dividend_next;
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.start) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
    end
  end

  assign sts.div_last = (div_cnt == skhst_pkg::DIV_CNT_W'(skhst_pkg::DIV_CYCLES - 1));

  // clearing pass over the valid store after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign sts.clr_last = (clr_cnt == AW'(SLOTS - 1));

  // slot memory
  assign addr = AW'(rem);
  assign do_store = cmd.commit && req && !rd_valid;
  assign wr_addr = cmd.clr_en ? clr_cnt : addr;

  always_ff @(posedge clk) begin
    if (cmd.clr_en || do_store) begin
      valid_mem[wr_addr] <= !cmd.clr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (do_store) begin
      rect_mem[addr] <= rect;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_rect <= rect_mem[addr];
      rd_valid <= valid_mem[addr];
    end
  end

  // rectangle shown after the access
  always_comb begin
    if (rd_valid) begin
      res_rect = rd_rect;
    end else if (req) begin
      res_rect = rect;
    end else begin
      res_rect = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ok <= req ? !rd_valid : rd_valid;
      out_x <= res_rect[15:0];
      out_y <= res_rect[31:16];
      out_w <= res_rect[47:32];
      out_h <= res_rect[63:48];
      slot_index <= rem[9:0];
    end
  end

  assign sts.out_busy = out_valid && out_stall;

endmodule

@@ src/string_keyed_hash_slot_table_core.sv @@
// top level of the string keyed hash slot table
`timescale 1ns / 1ps

// A name enters one byte per input word on the in channel (valid/stall);
// name_last marks its final byte, and req_type and the rectangle fields are
// taken from that word (1 insert, 0 lookup). Bytes that are not last are hashed
// as they are taken and give no output word. A last byte starts a 64-bit modulo
// of the hash by the slot count, 4 remainder bits per cycle, then a registered
// memory read and an update; input is stalled while these run. The result
// waits in an output register: a stall on the out channel holds it, and the
// block goes on hashing bytes of the next name, waiting only when it must
// deliver the next result. The user writes the slot count through
// cfg_we/cfg_data only while idle; the block itself does not enforce this.
// 0 acts as 1 and counts above SLOTS act as SLOTS.
// After reset the valid bits are cleared in a pass over all SLOTS slots, one
// slot a cycle, during which the input is stalled.

module string_keyed_hash_slot_table_core #(
  parameter int SLOTS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [skhst_pkg::MOD_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         req_type,
  input  logic [7:0]                   name_byte,
  input  logic                         name_last,
  input  logic [15:0]                  rect_x,
  input  logic [15:0]                  rect_y,
  input  logic [15:0]                  rect_w,
  input  logic [15:0]                  rect_h,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         ok,
  output logic [15:0]                  out_x,
  output logic [15:0]                  out_y,
  output logic [15:0]                  out_w,
  output logic [15:0]                  out_h,
  output logic [9:0]                   slot_index
);

  localparam int MW = skhst_pkg::MOD_W;

  logic [MW-1:0]    num_slots;
  logic [MW-1:0]    divisor;
  skhst_pkg::cmd_t  cmd;
  skhst_pkg::sts_t  sts;

  // slot count register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_slots <= MW'(1024);
    end else if (cfg_we) begin
      num_slots <= cfg_data;
    end
  end

  // effective modulus, clamped to one through SLOTS
  always_comb begin
    if (num_slots == '0) begin
      divisor = MW'(1);
    end else if (32'(num_slots) > SLOTS) begin
      divisor = MW'(SLOTS);
    end else begin
      divisor = num_slots;
    end
  end

  skhst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .name_last (name_last),
    .sts       (sts),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  skhst_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .divisor    (divisor),
    .req_type   (req_type),
    .name_byte  (name_byte),
    .rect_x     (rect_x),
    .rect_y     (rect_y),
    .rect_w     (rect_w),
    .rect_h     (rect_h),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ok         (ok),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_w      (out_w),
    .out_h      (out_h),
    .slot_index (slot_index)
  );

endmodule

@@ sim/tb_string_keyed_hash_slot_table_core.sv @@
// testbench for the djb2 keyed slot table: queued name words, predicted slot replies
`timescale 1ns / 1ps

module tb_string_keyed_hash_slot_table_core;

  localparam int SLOTS = 1024;
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 30;
  localparam int PHASE_WORDS = 145;
  localparam int POOL_NAMES = 12;
  localparam int NAME_MAX = 14;

  // one input word: a byte of a name plus the request fields
  typedef struct packed {
    logic        req;
    logic [7:0]  code;
    logic        last;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
  } name_word_t;

  // one output word: what the table reports for a finished name
  typedef struct packed {
    logic        ok;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [9:0]  slot;
  } slot_reply_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [skhst_pkg::MOD_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic req_type;
  logic [7:0] name_byte;
  logic name_last;
  logic [15:0] rect_x, rect_y, rect_w, rect_h;
  logic out_valid;
  logic out_stall;
  logic ok;
  logic [15:0] out_x, out_y, out_w, out_h;
  logic [9:0] slot_index;

  // shadow of the block's state
  logic [63:0] hash_acc;
  logic [63:0] rect_shadow [SLOTS];
  bit          slot_taken [SLOTS];
  logic [skhst_pkg::MOD_W-1:0] slot_count;

  name_word_t  name_words_q [$];
  slot_reply_t slot_replies_due [$];
  name_word_t  drive_word;
  slot_reply_t new_reply;
  slot_reply_t want_reply;
  slot_reply_t got_reply;

  logic [7:0] name_buf [NAME_MAX];
  logic [7:0] pool_bytes [POOL_NAMES][NAME_MAX];
  int         pool_len [POOL_NAMES];
  int         fail_count = 0;
  int         idle_cycles = 0;
  int         cycle_no = 0;
  logic [skhst_pkg::MOD_W-1:0] slot_settings [7] = '{11'd16, 11'd0, 11'd1, 11'd2047,
                                                      11'd37, 11'd1025, 11'd1000};

  string_keyed_hash_slot_table_core #(.SLOTS(SLOTS)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .name_byte(name_byte), .name_last(name_last),
    .rect_x(rect_x), .rect_y(rect_y), .rect_w(rect_w), .rect_h(rect_h),
    .out_valid(out_valid), .out_stall(out_stall),
    .ok(ok), .out_x(out_x), .out_y(out_y), .out_w(out_w), .out_h(out_h),
    .slot_index(slot_index)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end

  // random gaps on both sides, none in a quiet window mid-run
  function automatic bit take_break();
    if (cycle_no >= 3000 && cycle_no < 4500)
      return 1'b0;
    return $urandom_range(99) < 21;
  endfunction

  // hash one byte; on a last byte, access the table and form the reply
  function automatic bit djb2_table_step(input name_word_t wd, output slot_reply_t r);
    logic [63:0] h;
    logic [63:0] modulus;
    logic [63:0] idx;
    h = (hash_acc << 5) + hash_acc + {{56{wd.code[7]}}, wd.code};
    r = '0;
    if (!wd.last) begin
      hash_acc = h;
      return 1'b0;
    end
    hash_acc = skhst_pkg::HASH_INIT;
    if (slot_count == 0)
      modulus = 64'd1;
    else if (slot_count > SLOTS)
      modulus = 64'(SLOTS);
    else
      modulus = 64'(slot_count);
    idx = h % modulus;
    if (wd.req == REQ_INSERT) begin
      r.ok = !slot_taken[idx];
      if (!slot_taken[idx]) begin
        rect_shadow[idx] = {wd.h, wd.w, wd.y, wd.x};
        slot_taken[idx] = 1'b1;
      end
    end else begin
      r.ok = slot_taken[idx];
    end
    if (slot_taken[idx])
      {r.h, r.w, r.y, r.x} = rect_shadow[idx];
    r.slot = idx[9:0];
    return 1'b1;
  endfunction

  // driver: predict on acceptance, then present the next queued word
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (djb2_table_step(drive_word, new_reply))
          slot_replies_due.push_back(new_reply);
      end
      if (!in_valid || !in_stall) begin
        if (name_words_q.size() > 0 && !take_break()) begin
          drive_word = name_words_q.pop_front();
          in_valid <= 1'b1;
          req_type <= drive_word.req;
          name_byte <= drive_word.code;
          name_last <= drive_word.last;
          rect_x <= drive_word.x;
          rect_y <= drive_word.y;
          rect_w <= drive_word.w;
          rect_h <= drive_word.h;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted reply with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_reply = '{ok, out_x, out_y, out_w, out_h, slot_index};
        if (slot_replies_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected reply word: ok=%0b slot=%0d", ok, slot_index);
        end else begin
          want_reply = slot_replies_due.pop_front();
          if (got_reply.ok !== want_reply.ok || got_reply.x !== want_reply.x ||
              got_reply.y !== want_reply.y || got_reply.w !== want_reply.w ||
              got_reply.h !== want_reply.h || got_reply.slot !== want_reply.slot) begin
            fail_count++;
            if (fail_count <= 10)
              $display("reply mismatch: expected ok=%0b x=%h y=%h w=%h h=%h slot=%0d, %s",
                       want_reply.ok, want_reply.x, want_reply.y, want_reply.w,
                       want_reply.h, want_reply.slot,
                       $sformatf("got ok=%0b x=%h y=%h w=%h h=%h slot=%0d",
                                 got_reply.ok, got_reply.x, got_reply.y, got_reply.w,
                                 got_reply.h, got_reply.slot));
          end
        end
      end
      out_stall <= take_break();
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // random byte with extra weight on zero and the sign boundary
  function automatic logic [7:0] rand_code();
    case ($urandom_range(19))
      0: return 8'h00;
      1: return 8'h7f;
      2: return 8'h80;
      3: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // fill name_buf with a fresh name, mostly short
  function automatic int make_name();
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(NAME_MAX, 9) : $urandom_range(6, 1);
    for (int i = 0; i < len; i++)
      name_buf[i] = rand_code();
    return len;
  endfunction

  // queue the bytes of name_buf as one request
  task automatic emit_name(input logic req, input int len, input logic [63:0] rect);
    name_word_t wd;
    for (int i = 0; i < len; i++) begin
      wd.req = req;
      wd.code = name_buf[i];
      wd.last = (i == len - 1);
      {wd.h, wd.w, wd.y, wd.x} = rect;
      name_words_q.push_back(wd);
    end
  endtask

  // mostly reuse a small pool of names so inserts and lookups meet
  task automatic run_random(input int budget);
    int sent;
    int len;
    int k;
    logic req;
    sent = 0;
    for (int p = 0; p < POOL_NAMES; p++) begin
      pool_len[p] = make_name();
      for (int i = 0; i < pool_len[p]; i++)
        pool_bytes[p][i] = name_buf[i];
    end
    while (sent < budget) begin
      if ($urandom_range(99) < 85) begin
        k = $urandom_range(POOL_NAMES - 1);
        len = pool_len[k];
        for (int i = 0; i < len; i++)
          name_buf[i] = pool_bytes[k][i];
      end else begin
        len = make_name();
      end
      req = ($urandom_range(99) < 40) ? REQ_INSERT : REQ_LOOKUP;
      emit_name(req, len, {$urandom, $urandom});
      sent += len;
    end
  endtask

  // wait for the block to drain, then a margin for a name still hashing
  task automatic settle();
    while (name_words_q.size() != 0 || in_valid || slot_replies_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_slots(input logic [skhst_pkg::MOD_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    slot_count = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    req_type = 1'b0;
    name_byte = '0;
    name_last = 1'b0;
    rect_x = '0;
    rect_y = '0;
    rect_w = '0;
    rect_h = '0;
    out_stall = 1'b0;
    hash_acc = skhst_pkg::HASH_INIT;
    slot_count = 11'd1024;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // lookup on an empty table, insert, insert into occupied, lookup hit
    name_buf[0] = 8'h00;
    emit_name(REQ_LOOKUP, 1, 64'h0);
    emit_name(REQ_INSERT, 1, 64'hffff_ffff_ffff_ffff);
    emit_name(REQ_INSERT, 1, 64'h1234_5678_9abc_def0);
    emit_name(REQ_LOOKUP, 1, 64'h0);
    // zero byte inside a name does not end it
    name_buf[0] = 8'h41;
    name_buf[1] = 8'h00;
    name_buf[2] = 8'h42;
    emit_name(REQ_INSERT, 3, 64'h0);
    // bytes with the sign bit set are sign extended
    name_buf[0] = 8'h80;
    name_buf[1] = 8'hff;
    name_buf[2] = 8'h7f;
    emit_name(REQ_INSERT, 3, {$urandom, $urandom});
    emit_name(REQ_LOOKUP, 3, {$urandom, $urandom});
    // long name wraps the 64-bit accumulator
    for (int i = 0; i < 12; i++)
      name_buf[i] = 8'h7a;
    emit_name(REQ_INSERT, 12, {$urandom, $urandom});

    run_random(PHASE_WORDS);
    settle();

    // slot counts: small, zero, one, all ones, odd, just above range, near range
    foreach (slot_settings[s]) begin
      set_slots(slot_settings[s]);
      run_random(PHASE_WORDS);
      settle();
    end

    if (fail_count == 0 && slot_replies_due.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
src/skhst_pkg.sv
src/skhst_ctrl.sv
src/skhst_dpath.sv
src/string_keyed_hash_slot_table_core.sv
sim/tb_string_keyed_hash_slot_table_core.sv
